// ===== rtl/mpid_pkg.sv =====
// Shared types, widths, register indexes and reset values for the multichannel PID speed loop.
package mpid_pkg;

  localparam int NUM_CH_DEF = 8;

  localparam int CH_W    = 3;
  localparam int RPM_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int INTEG_W = 32;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN   = 2'd2;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd2304;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 16'd179;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 16'd256;
  localparam logic [LIM_W-1:0]  OUTPUT_LIMIT_RST = 15'd5000;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  output_limit;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
  } upd_t;

endpackage

// ===== rtl/multichannel_pid_speed_loop_top.sv =====
// Top level of the multichannel PID speed loop: config registers, state RAM and update stage.
//
// Usage: each input item on the in_valid_i/in_ready_o channel names a motor channel
// and carries a target and a measured speed. The block keeps an integral and the last
// error per channel in a state RAM and returns one drive item per in-range item on
// the out_valid_o/out_ready_i channel, in order. Items whose channel is not below
// NUM_CHANNELS are accepted and dropped without touching any state.
// An item passes stages s1, a, b, c and d in order. The block takes one item per cycle
// unless the receiver stalls, also for repeated hits on one channel: the state RAM is
// read when an item is accepted and written when it leaves s1, and the last write is
// forwarded to the following item. The user writes gains and the limit through cfg_we_i/
// cfg_idx_i/cfg_wdata_i only while the block is idle; the block does not enforce this.
// Reset restores the default gains and limit and marks every channel's state as zero
// through per-channel valid bits, so items are accepted from the first cycle on.
// When the receiver stalls, the result register holds its item and the stages behind
// it keep filling their empty slots; in_ready_o drops only when all stages are full.
module multichannel_pid_speed_loop_top
  import mpid_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CH_W-1:0]         channel_i,
  input  logic signed [RPM_W-1:0] target_rpm_i,
  input  logic signed [RPM_W-1:0] measured_rpm_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CH_W-1:0]         out_channel_o,
  output logic signed [RPM_W-1:0] drive_o,
  output logic                    clamped_o
);

  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MEM_W = INTEG_W + ERR_W;

  cfg_t cfg_q;

  logic accept, in_range, rd_en;
  logic [AW-1:0] rd_addr;

  logic                    s1_v_q;
  logic [CH_W-1:0]         s1_ch_q;
  logic signed [ERR_W-1:0] s1_err_q;
  logic [AW-1:0]           s1_addr;

  logic [MEM_W-1:0]          ram_rdata;
  logic                      ram_we;
  logic signed [INTEG_W-1:0] old_integ;
  logic signed [ERR_W-1:0]   old_err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_new;

  logic [NUM_CHANNELS-1:0]   vld_q;
  logic                      lw_v_q;
  logic [AW-1:0]             lw_addr_q;
  logic signed [INTEG_W-1:0] lw_integ_q;
  logic signed [ERR_W-1:0]   lw_err_q;

  upd_t upd;
  logic upd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= PROP_GAIN_RST;
      cfg_q.integ_gain   <= INTEG_GAIN_RST;
      cfg_q.deriv_gain   <= DERIV_GAIN_RST;
      cfg_q.output_limit <= OUTPUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !s1_v_q || upd_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(channel_i) < 32'(NUM_CHANNELS);
  assign rd_en      = accept && in_range;
  assign rd_addr    = AW'(channel_i);
  assign s1_addr    = AW'(s1_ch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_ch_q  <= channel_i;
      s1_err_q <= ERR_W'(target_rpm_i) - ERR_W'(measured_rpm_i);
    end
  end

  mpid_ram #(
    .WIDTH(MEM_W),
    .DEPTH(NUM_CHANNELS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr),
    .wdata_i({integ_new, s1_err_q}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // The most recent write wins over the RAM, whose read may predate it.
  always_comb begin
    if (lw_v_q && (lw_addr_q == s1_addr)) begin
      old_integ = lw_integ_q;
      old_err   = lw_err_q;
    end else if (vld_q[s1_addr]) begin
      old_integ = $signed(ram_rdata[MEM_W-1:ERR_W]);
      old_err   = $signed(ram_rdata[ERR_W-1:0]);
    end else begin
      old_integ = '0;
      old_err   = '0;
    end
  end

  always_comb begin
    integ_sum = (INTEG_W+1)'(old_integ) + (INTEG_W+1)'(s1_err_q);
    integ_new = integ_sum[INTEG_W-1:0];
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  assign ram_we = s1_v_q && upd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      lw_v_q <= 1'b0;
    end else if (ram_we) begin
      vld_q[s1_addr] <= 1'b1;
      lw_v_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_addr_q  <= s1_addr;
      lw_integ_q <= integ_new;
      lw_err_q   <= s1_err_q;
    end
  end

  always_comb begin
    upd.ch    = s1_ch_q;
    upd.err   = s1_err_q;
    upd.integ = integ_new;
    upd.diff  = DIFF_W'(s1_err_q) - DIFF_W'(old_err);
  end

  mpid_math u_math (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .upd_valid_i  (s1_v_q),
    .upd_ready_o  (upd_ready),
    .upd_i        (upd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_channel_o(out_channel_o),
    .drive_o      (drive_o),
    .clamped_o    (clamped_o)
  );

  a_drop_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_range) |=> !s1_v_q)
    else $error("An item with an out-of-range channel entered the update stage.");

  a_forward_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (lw_v_q && (lw_addr_q == $past(s1_addr)) && vld_q[lw_addr_q]))
    else $error("The forwarding register does not hold the last state write.");

  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (($signed(drive_o) <= $signed({1'b0, cfg_q.output_limit}))
                  && ($signed(drive_o) >= -$signed({1'b0, cfg_q.output_limit}))))
    else $error("The drive item lies outside the output limit.");

  a_clamp_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamped_o) |-> (($signed(drive_o) == $signed({1'b0, cfg_q.output_limit}))
                  || ($signed(drive_o) == -$signed({1'b0, cfg_q.output_limit}))))
    else $error("A clamped drive item is not at the limit.");

endmodule

// ===== rtl/mpid_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpid_math.sv =====
// Gain multiply, sum and shift, and output clamp pipeline with the result register.
module mpid_math
  import mpid_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    upd_valid_i,
  output logic                    upd_ready_o,
  input  upd_t                    upd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CH_W-1:0]         out_channel_o,
  output logic signed [RPM_W-1:0] drive_o,
  output logic                    clamped_o
);

  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int I_W   = GAIN_W + 1 + INTEG_W;
  localparam int D_W   = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W = I_W + 1;
  localparam int Q_W   = SUM_W - 8;

  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic ra, rb, rc, rd;

  upd_t a_q;

  logic [CH_W-1:0]       b_ch_q;
  logic signed [P_W-1:0] b_p_q, b_p_d;
  logic signed [I_W-1:0] b_i_q, b_i_d;
  logic signed [D_W-1:0] b_d_q, b_d_d;

  logic [CH_W-1:0]         c_ch_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   c_q;

  logic signed [Q_W-1:0]   lim_pos, lim_neg;
  logic signed [RPM_W-1:0] drive_d;
  logic                    clamp_d;

  logic [CH_W-1:0]         d_ch_q;
  logic signed [RPM_W-1:0] d_drive_q;
  logic                    d_clamp_q;

  assign rd = !d_v_q || out_ready_i;
  assign rc = !c_v_q || rd;
  assign rb = !b_v_q || rc;
  assign ra = !a_v_q || rb;
  assign upd_ready_o = ra;

  always_comb begin
    b_p_d = $signed({1'b0, cfg_i.prop_gain}) * a_q.err;
    b_i_d = $signed({1'b0, cfg_i.integ_gain}) * a_q.integ;
    b_d_d = $signed({1'b0, cfg_i.deriv_gain}) * a_q.diff;
  end

  assign sum = SUM_W'(b_p_q) + SUM_W'(b_i_q) + SUM_W'(b_d_q);

  always_comb begin
    lim_pos = $signed({{(Q_W-LIM_W){1'b0}}, cfg_i.output_limit});
    lim_neg = -lim_pos;
    drive_d = c_q[RPM_W-1:0];
    clamp_d = 1'b0;
    if (c_q > lim_pos) begin
      drive_d = lim_pos[RPM_W-1:0];
      clamp_d = 1'b1;
    end else if (c_q < lim_neg) begin
      drive_d = lim_neg[RPM_W-1:0];
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (ra) a_v_q <= upd_valid_i;
      if (rb) b_v_q <= a_v_q;
      if (rc) c_v_q <= b_v_q;
      if (rd) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra && upd_valid_i) begin
      a_q <= upd_i;
    end
    if (rb && a_v_q) begin
      b_ch_q <= a_q.ch;
      b_p_q  <= b_p_d;
      b_i_q  <= b_i_d;
      b_d_q  <= b_d_d;
    end
    if (rc && b_v_q) begin
      c_ch_q <= b_ch_q;
      c_q    <= sum[SUM_W-1:8];
    end
    if (rd && c_v_q) begin
      d_ch_q    <= c_ch_q;
      d_drive_q <= drive_d;
      d_clamp_q <= clamp_d;
    end
  end

  assign out_valid_o   = d_v_q;
  assign out_channel_o = d_ch_q;
  assign drive_o       = d_drive_q;
  assign clamped_o     = d_clamp_q;

endmodule
